FILE: src/taylor_series_exp_sin_cos_defines.svh
// Assertion macros used by the top level of the series evaluator.
`ifndef TAYLOR_SERIES_EXP_SIN_COS_DEFINES_SVH
`define TAYLOR_SERIES_EXP_SIN_COS_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TSES_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TSES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/tses_pkg.sv
// Package with types, constants and codes of the series evaluator.
package tses_pkg;

  localparam int MAX_TERMS = 9;
  localparam int FRAC_BITS = 16;
  localparam int T_W       = 4;
  localparam int X_W       = 24;
  localparam int SUM_W     = 48;
  localparam int MAG_W     = SUM_W - 1;
  localparam int LO_W      = 24;
  localparam int HI_W      = MAG_W - LO_W;
  localparam int PROD_W    = MAG_W + X_W;
  localparam int S_W       = PROD_W - FRAC_BITS;
  localparam int DIV_CHUNK = 8;
  localparam int DIV_STEPS = (S_W + 1 + DIV_CHUNK - 1) / DIV_CHUNK;
  localparam int DIV_W     = DIV_STEPS * DIV_CHUNK;
  localparam int DS_W      = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int KMAX      = 2 * MAX_TERMS + 1;
  localparam int K_W       = $clog2(KMAX + 1);

  typedef enum logic [1:0] {
    OP_EXP  = 2'd0,
    OP_SIN  = 2'd1,
    OP_COS  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV_LOAD,
    ST_DIV,
    ST_MAG,
    ST_ACC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [T_W-1:0]        term_count;
    logic signed [X_W-1:0] x_value;
  } req_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] series_sum;
    logic                    overflow;
  } res_t;

  typedef struct packed {
    logic           load;
    logic           mul_lo;
    logic           mul_hi;
    logic           div_load;
    logic           div_step;
    logic           mag_update;
    logic           acc_add;
    logic           acc_neg_base;
    logic           acc_use_xsign;
    logic [K_W-1:0] k;
  } cmd_t;

  typedef struct packed {
    logic mag_clamped;
    logic sum_clamped;
  } status_t;

endpackage

FILE: src/taylor_series_exp_sin_cos.sv
// Top level of the fixed-point exp, sine and cosine series evaluator.
//
// A request (opcode, term count, argument with 16 fraction bits) is taken at a
// rising edge where start is high and busy is low. Busy stays high until the
// result has been shown. The result is on the result port for exactly one cycle
// with result_valid high; the receiver cannot hold it off, so it must take it then.
// Let K be the highest power used: the term count for exp, twice it plus one for
// sine, twice it for cosine, after the count is limited to nine.
// Each power after the first runs on a 24x24 multiplier for the low
// half of the term, a 23x24 multiplier for the high half and a divider that
// resolves 8 quotient bits per cycle: a low multiply, a high multiply, a rounding
// step, seven divide steps, a clamp step and an accumulate step.
// The result strobe follows the accumulate step of the highest power, and the
// next request can be taken in the cycle after the strobe. The unused opcode
// shows a zero sum in the cycle after the accepting edge and then returns to
// idle. Reset returns the controller to idle and drops busy and the strobe.
`include "taylor_series_exp_sin_cos_defines.svh"

module taylor_series_exp_sin_cos
  import tses_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t request,
  output logic busy,
  output logic result_valid,
  output res_t result
);

  cmd_t    cmd;
  status_t status;
  logic    any_clamp;
  logic    null_req;
  logic    null_res;

  tses_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .request      (request),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid),
    .any_clamp    (any_clamp)
  );

  tses_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .status  (status),
    .result  (result)
  );

  assign null_req = start && !busy && (request.opcode == OP_NONE);
  assign null_res = result_valid && (result.series_sum == '0) && !result.overflow;

  `TSES_ASSERT_SAME(a_strobe_busy, clk, rst, result_valid, busy, "result strobe while idle")
  `TSES_ASSERT_NEXT(a_strobe_idle, clk, rst, result_valid, !busy && !result_valid, "double strobe")
  `TSES_ASSERT_NEXT(a_clamp_flag, clk, rst, any_clamp && !cmd.load, result.overflow, "clamp lost")
  `TSES_ASSERT_NEXT(a_null_op, clk, rst, null_req, null_res, "bad null result")

endmodule

FILE: src/tses_ctrl.sv
// Controller state machine that sequences the series terms.
module tses_ctrl
  import tses_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  req_t    request,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy,
  output logic    result_valid,
  output logic    any_clamp
);

  state_t           state;
  state_t           state_next;
  logic [1:0]       op;
  logic [K_W-1:0]   k;
  logic [K_W-1:0]   kmax;
  logic [DS_W-1:0]  div_cnt;
  logic [T_W-1:0]   t_sat;
  logic [K_W-1:0]   kmax_load;
  logic             accept;

  assign accept = (state == ST_IDLE) && start;

  always_comb begin
    t_sat = (request.term_count > T_W'(MAX_TERMS)) ? T_W'(MAX_TERMS) : request.term_count;
    case (request.opcode)
      OP_EXP:  kmax_load = K_W'(t_sat);
      OP_SIN:  kmax_load = K_W'({t_sat, 1'b1});
      OP_COS:  kmax_load = K_W'({t_sat, 1'b0});
      default: kmax_load = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op      <= OP_NONE;
      k       <= '0;
      kmax    <= '0;
      div_cnt <= '0;
    end else begin
      if (accept) begin
        op   <= request.opcode;
        k    <= '0;
        kmax <= kmax_load;
      end
      if ((state == ST_ACC) && (k != kmax)) begin
        k <= k + K_W'(1);
      end
      if (state == ST_DIV_LOAD) begin
        div_cnt <= '0;
      end else if (state == ST_DIV) begin
        div_cnt <= div_cnt + DS_W'(1);
      end
    end
  end

  always_comb begin
    state_next        = state;
    cmd               = '0;
    cmd.k             = k;
    cmd.load          = accept;
    cmd.acc_neg_base  = ((op == OP_SIN) || (op == OP_COS)) && k[1];
    cmd.acc_use_xsign = ((op == OP_EXP) && k[0]) || (op == OP_SIN);
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (request.opcode == OP_NONE) ? ST_DONE : ST_ACC;
        end
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt == DS_W'(DIV_STEPS - 1)) begin
          state_next = ST_MAG;
        end
      end
      ST_MAG: begin
        cmd.mag_update = 1'b1;
        state_next     = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_add = (op == OP_EXP) || ((op == OP_SIN) && k[0]) ||
                      ((op == OP_COS) && !k[0]);
        state_next  = (k == kmax) ? ST_DONE : ST_MUL_LO;
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy         = (state != ST_IDLE);
  assign result_valid = (state == ST_DONE);
  assign any_clamp    = (cmd.mag_update && status.mag_clamped) ||
                        (cmd.acc_add && status.sum_clamped);

endmodule

FILE: src/tses_dp.sv
// Datapath with the low and high multipliers, chunked divider and saturating accumulator.
module tses_dp
  import tses_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  req_t    request,
  input  cmd_t    cmd,
  output status_t status,
  output res_t    result
);

  localparam logic [MAG_W-1:0]  MAG_MAX  = {MAG_W{1'b1}};
  localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

  logic [X_W-1:0]        x_abs;
  logic                  x_neg;
  logic [MAG_W-1:0]      mag;
  logic [LO_W+X_W-1:0]   prod_lo;
  logic [DIV_W-1:0]      div_reg;
  logic [K_W-1:0]        rem;
  logic [SUM_W-1:0]      acc;
  logic                  ovf;

  logic [HI_W+X_W-1:0]   prod_hi;
  logic [PROD_W-1:0]     prod_full;
  logic [DIV_W-1:0]      div_d;
  logic [K_W-1:0]        div_r;
  logic [K_W:0]          div_t;
  logic                  add_neg;
  logic [SUM_W:0]        acc_ext;
  logic [SUM_W:0]        mag_ext;
  logic [SUM_W:0]        sum_raw;
  logic [SUM_W-1:0]      sum_sat;
  logic                  sum_ovf;
  logic                  mag_big;

  assign prod_hi   = mag[MAG_W-1:LO_W] * x_abs;
  assign prod_full = {prod_hi, {LO_W{1'b0}}} + PROD_W'(prod_lo) + RND_HALF;

  always_comb begin
    div_d = div_reg;
    div_r = rem;
    for (int i = 0; i < DIV_CHUNK; i++) begin
      div_t = {div_r, div_d[DIV_W-1]};
      div_d = {div_d[DIV_W-2:0], 1'b0};
      if (div_t >= {1'b0, cmd.k}) begin
        div_r    = K_W'(div_t - {1'b0, cmd.k});
        div_d[0] = 1'b1;
      end else begin
        div_r = div_t[K_W-1:0];
      end
    end
  end

  assign mag_big = (div_reg[DIV_W-1:MAG_W] != '0);

  always_comb begin
    add_neg = cmd.acc_neg_base ^ (cmd.acc_use_xsign & x_neg);
    acc_ext = {acc[SUM_W-1], acc};
    mag_ext = (SUM_W + 1)'(mag);
    sum_raw = add_neg ? (acc_ext - mag_ext) : (acc_ext + mag_ext);
    sum_ovf = (sum_raw[SUM_W] != sum_raw[SUM_W-1]);
    if (!sum_ovf) begin
      sum_sat = sum_raw[SUM_W-1:0];
    end else if (sum_raw[SUM_W]) begin
      sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      ovf <= 1'b0;
    end else if (cmd.load) begin
      acc <= '0;
      ovf <= 1'b0;
    end else begin
      if (cmd.mag_update && mag_big) begin
        ovf <= 1'b1;
      end
      if (cmd.acc_add) begin
        acc <= sum_sat;
        if (sum_ovf) begin
          ovf <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_neg <= request.x_value[X_W-1];
      x_abs <= request.x_value[X_W-1] ? (~request.x_value + X_W'(1)) : request.x_value;
      mag   <= MAG_W'(1) << FRAC_BITS;
    end
    if (cmd.mul_lo) begin
      prod_lo <= mag[LO_W-1:0] * x_abs;
    end
    if (cmd.mul_hi) begin
      div_reg <= DIV_W'(prod_full[PROD_W-1:FRAC_BITS]);
    end
    if (cmd.div_load) begin
      div_reg <= div_reg + DIV_W'(cmd.k >> 1);
      rem     <= '0;
    end
    if (cmd.div_step) begin
      div_reg <= div_d;
      rem     <= div_r;
    end
    if (cmd.mag_update) begin
      mag <= mag_big ? MAG_MAX : div_reg[MAG_W-1:0];
    end
  end

  assign status.mag_clamped = mag_big;
  assign status.sum_clamped = sum_ovf;
  assign result.series_sum  = acc;
  assign result.overflow    = ovf;

endmodule

FILE: dv/taylor_series_exp_sin_cos_tb.sv
// Testbench of the fixed-point exp, sine and cosine series evaluator.
module taylor_series_exp_sin_cos_tb;
  import tses_pkg::*;

  localparam int     LIMIT_CYCLES = 1_000_000;
  localparam int     TAIL_CYCLES  = 240;
  localparam int     REPORT_MAX   = 10;
  localparam longint SUM_HI       = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_LO       = -SUM_HI - 1;
  localparam longint unsigned MAG_LIMIT = (64'd1 << MAG_W) - 1;
  localparam longint unsigned LO_MASK   = (64'd1 << LO_W) - 1;

  localparam logic signed [X_W-1:0] X_MAX = {1'b0, {(X_W-1){1'b1}}};
  localparam logic signed [X_W-1:0] X_MIN = {1'b1, {(X_W-1){1'b0}}};
  localparam logic signed [X_W-1:0] X_ONE = 24'sd65536;
  localparam logic signed [X_W-1:0] X_PI  = 24'sd205887;

  logic clk;
  logic rst;
  logic start;
  req_t request;
  logic busy;
  logic result_valid;
  res_t result;

  res_t pending_sums[$];
  int   mismatch_count;
  int   cycle_count;

  taylor_series_exp_sin_cos u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .request      (request),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic res_t predict_series(input req_t r);
    res_t              res;
    logic [X_W-1:0]    raw;
    logic              x_neg;
    longint unsigned   ax, mag, hi, lo, hp, lp, s, q, kk;
    longint            acc;
    logic              ovf;
    logic              use_term;
    logic              neg;
    int unsigned       terms;
    int unsigned       kmax;
    raw   = r.x_value;
    x_neg = raw[X_W-1];
    ax    = x_neg ? ((64'd1 << X_W) - raw) : raw;
    terms = 32'(r.term_count);
    if (terms > MAX_TERMS) terms = MAX_TERMS;
    res = '0;
    if (op_t'(r.opcode) == OP_NONE) return res;
    case (op_t'(r.opcode))
      OP_EXP:  kmax = terms;
      OP_SIN:  kmax = 2 * terms + 1;
      default: kmax = 2 * terms;
    endcase
    ovf = 1'b0;
    acc = 0;
    mag = 64'd1 << FRAC_BITS;
    for (int unsigned k = 0; k <= kmax; k++) begin
      if (k > 0) begin
        kk = 64'(k);
        hi = mag >> LO_W;
        lo = mag & LO_MASK;
        hp = hi * ax;
        lp = lo * ax;
        s  = (hp << (LO_W - FRAC_BITS)) + ((lp + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
        q  = (s + kk / 2) / kk;
        if (q > MAG_LIMIT) begin
          q   = MAG_LIMIT;
          ovf = 1'b1;
        end
        mag = q;
      end
      case (op_t'(r.opcode))
        OP_EXP: begin
          use_term = 1'b1;
          neg      = x_neg && k[0];
        end
        OP_SIN: begin
          use_term = k[0];
          neg      = k[1] != x_neg;
        end
        default: begin
          use_term = !k[0];
          neg      = k[1];
        end
      endcase
      if (use_term) begin
        acc = neg ? acc - longint'(mag) : acc + longint'(mag);
        if (acc > SUM_HI) begin
          acc = SUM_HI;
          ovf = 1'b1;
        end else if (acc < SUM_LO) begin
          acc = SUM_LO;
          ovf = 1'b1;
        end
      end
    end
    res.series_sum = acc[SUM_W-1:0];
    res.overflow   = ovf;
    return res;
  endfunction

  task automatic send_request(input op_t op, input logic [T_W-1:0] tc,
                              input logic signed [X_W-1:0] x);
    req_t req;
    int   gap;
    req.opcode     = op;
    req.term_count = tc;
    req.x_value    = x;
    gap = $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    pending_sums.push_back(predict_series(req));
  endtask

  task automatic drain_requests();
    @(negedge clk);
    start <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
  endtask

  task automatic test_exp();
    send_request(OP_EXP, 4'd0, '0);
    send_request(OP_EXP, 4'd9, X_ONE);
    send_request(OP_EXP, 4'd9, -X_ONE);
    send_request(OP_EXP, 4'd9, X_MAX);
    send_request(OP_EXP, 4'd15, X_MIN);
  endtask

  task automatic test_sin();
    send_request(OP_SIN, 4'd5, 24'sd102944);
    send_request(OP_SIN, 4'd9, -X_PI);
    send_request(OP_SIN, 4'd9, X_MAX);
    send_request(OP_SIN, 4'd9, X_MIN);
    send_request(OP_SIN, 4'd0, 24'sd1);
  endtask

  task automatic test_cos();
    send_request(OP_COS, 4'd0, '0);
    send_request(OP_COS, 4'd9, X_PI);
    send_request(OP_COS, 4'd9, X_MIN);
    send_request(OP_COS, 4'd3, X_MAX);
    send_request(OP_COS, 4'd15, -24'sd131072);
  endtask

  task automatic test_unused_opcode();
    send_request(OP_NONE, 4'd15, X_MAX);
    send_request(OP_NONE, 4'd0, X_MIN);
  endtask

  task automatic test_term_saturation();
    send_request(OP_EXP, 4'd10, 24'sd131072);
    send_request(OP_SIN, 4'd15, 24'sd131072);
    send_request(OP_COS, 4'd12, -24'sd196608);
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 4; i++)
      send_request(op_t'($urandom_range(0, 2)), 4'($urandom_range(0, 15)), X_ONE);
    drain_requests();
    send_request(OP_EXP, 4'd2, 24'sd32768);
  endtask

  task automatic test_random(input int n);
    op_t                   op;
    logic [T_W-1:0]        tc;
    logic signed [X_W-1:0] x;
    int                    mode;
    for (int i = 0; i < n; i++) begin
      op   = ($urandom_range(0, 99) < 4) ? OP_NONE : op_t'($urandom_range(0, 2));
      tc   = T_W'($urandom_range(0, 15));
      mode = $urandom_range(0, 9);
      if (mode < 5) x = X_W'($urandom_range(0, 4 << FRAC_BITS));
      else if (mode < 7) x = X_W'($urandom_range(0, 32 << FRAC_BITS));
      else if (mode < 9) x = X_W'($urandom);
      else begin
        case ($urandom_range(0, 3))
          0:       x = X_MAX;
          1:       x = X_MIN;
          2:       x = X_ONE;
          default: x = '0;
        endcase
      end
      if (mode < 7 && $urandom_range(0, 1)) x = -x;
      send_request(op, tc, x);
      if (i % 100 == 99) drain_requests();
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst && result_valid) begin
      if (pending_sums.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("Result with no request waiting: sum %0d overflow %0b",
                   result.series_sum, result.overflow);
      end else begin
        want = pending_sums.pop_front();
        if (result.series_sum !== want.series_sum || result.overflow !== want.overflow) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("Mismatch: expected sum %0d overflow %0b, got sum %0d overflow %0b",
                     want.series_sum, want.overflow, result.series_sum, result.overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    mismatch_count = 0;
    cycle_count    = 0;
    rst            = 1'b1;
    start          = 1'b0;
    request        = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_exp();
    test_sin();
    test_cos();
    test_unused_opcode();
    test_term_saturation();
    test_drain_pause();
    test_random(430);
    drain_requests();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/tses_pkg.sv
src/tses_ctrl.sv
src/tses_dp.sv
src/taylor_series_exp_sin_cos.sv
dv/taylor_series_exp_sin_cos_tb.sv
